// ===== src/pot_size_class_slab_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef POT_SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define POT_SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psa assertion failed");

// Next-cycle implication, disabled while in reset.
`define PSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psa assertion failed");

`endif

// ===== src/psa_pkg.sv =====
// Package: constants, types and helpers of the size-class allocator.
`default_nettype none
package psa_pkg;

    localparam int PAGE_BYTES      = 4096;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int CLASS_COUNT     = 8;
    localparam int HEADER_BYTES    = 8;
    localparam int REGION_PAGES    = 256;

    localparam int ADDR_W     = 20;
    localparam int SIZE_W     = 20;
    localparam int NEED_W     = SIZE_W + 1;
    localparam int MIN_SHIFT  = $clog2(MIN_BLOCK_BYTES);
    localparam int IDX_W      = ADDR_W - MIN_SHIFT;
    localparam int HEAD_W     = IDX_W + 1;
    localparam int CLASS_W    = 3;
    localparam int PAGE_CNT_W = 9;
    localparam int OFF_W      = $clog2(PAGE_BYTES / MIN_BLOCK_BYTES);
    localparam int SLOTS      = 1 << IDX_W;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_CARVE,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_FREE_RD,
        ST_FREE_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [HEAD_W-1:0]  wdata;
    } link_req_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [CLASS_W-1:0] wdata;
    } cls_req_t;

    typedef struct packed {
        logic               too_large;
        logic [CLASS_W-1:0] cls;
    } class_sel_t;

    // Pick the smallest class whose block holds the request plus header.
    function automatic class_sel_t class_of(input logic [NEED_W-1:0] need);
        class_sel_t r;
        r.too_large = need > NEED_W'(MIN_BLOCK_BYTES << (CLASS_COUNT - 1));
        r.cls       = CLASS_W'(CLASS_COUNT - 1);
        for (int k = CLASS_COUNT - 1; k >= 0; k--)
        begin
            if (need <= NEED_W'(MIN_BLOCK_BYTES << k))
            begin
                r.cls = CLASS_W'(k);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/psa_if.sv =====
// Channel interfaces: request, response and configuration write.
`default_nettype none
interface psa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [psa_pkg::SIZE_W-1:0]    size;
    logic [psa_pkg::ADDR_W-1:0]    address;
    modport source (output valid, output op, output size, output address, input ready);
    modport sink   (input valid, input op, input size, input address, output ready);
endinterface

interface psa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [psa_pkg::ADDR_W-1:0]    address_out;
    modport source (output valid, output status, output address_out, input ready);
    modport sink   (input valid, input status, input address_out, output ready);
endinterface

interface psa_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [psa_pkg::PAGE_CNT_W-1:0]    reserved_pages;
    modport source (output valid, output reserved_pages, input ready);
    modport sink   (input valid, input reserved_pages, output ready);
endinterface
`default_nettype wire

// ===== src/psa_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== src/psa_seq.sv =====
// Sequencer: class heads, page carving, pop and push over the link and class RAMs.
`default_nettype none
`include "pot_size_class_slab_allocator_assert.svh"
module psa_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    psa_req_if.sink                             req,
    psa_rsp_if.source                           rsp,
    psa_cfg_if.sink                             cfg,
    output      psa_pkg::link_req_t             link_req,
    input  wire logic [psa_pkg::HEAD_W-1:0]     link_rdata,
    output      psa_pkg::cls_req_t              cls_req,
    input  wire logic [psa_pkg::CLASS_W-1:0]    cls_rdata
);
    psa_pkg::state_t state_reg, state_next;

    logic [psa_pkg::HEAD_W-1:0]     head_reg [psa_pkg::CLASS_COUNT];
    logic [psa_pkg::HEAD_W-1:0]     head_next [psa_pkg::CLASS_COUNT];
    logic [psa_pkg::PAGE_CNT_W-1:0] pages_reg, pages_next;
    logic [psa_pkg::PAGE_CNT_W-1:0] reserved_reg, reserved_next;
    logic [psa_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [psa_pkg::IDX_W-1:0]      blk_reg, blk_next;
    logic [psa_pkg::CLASS_W-1:0]    cls_reg, cls_next;
    logic [psa_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [1:0]                     res_status_reg, res_status_next;
    logic [psa_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [1:0]                     rsp_status_reg, rsp_status_next;
    logic [psa_pkg::ADDR_W-1:0]     rsp_addr_reg, rsp_addr_next;

    psa_pkg::class_sel_t            sel;
    logic [psa_pkg::PAGE_CNT_W-1:0] limit;
    logic [psa_pkg::OFF_W:0]        off_sum;
    logic [psa_pkg::IDX_W-1:0]      carve_idx;
    logic [psa_pkg::IDX_W-1:0]      head_idx;
    logic [psa_pkg::ADDR_W-1:0]     free_off;
    logic                           acc;

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == psa_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.address_out = rsp_addr_reg;

    assign sel   = psa_pkg::class_of(psa_pkg::NEED_W'(size_reg)
                   + psa_pkg::NEED_W'(psa_pkg::HEADER_BYTES));
    assign limit = (reserved_reg < psa_pkg::PAGE_CNT_W'(psa_pkg::REGION_PAGES))
                   ? reserved_reg : psa_pkg::PAGE_CNT_W'(psa_pkg::REGION_PAGES);
    // Adder: step through the page one block at a time.
    assign off_sum   = {1'b0, off_reg} + ((psa_pkg::OFF_W+1)'(1) << cls_reg);
    assign carve_idx = psa_pkg::IDX_W'({pages_reg, off_reg});
    assign head_idx  = head_reg[cls_reg][psa_pkg::IDX_W-1:0];
    assign free_off  = req.address - psa_pkg::ADDR_W'(psa_pkg::HEADER_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psa_pkg::ST_IDLE;
            pages_reg     <= '0;
            reserved_reg  <= psa_pkg::PAGE_CNT_W'(psa_pkg::REGION_PAGES);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < psa_pkg::CLASS_COUNT; i++)
            begin
                head_reg[i] <= psa_pkg::HEAD_W'(1) << psa_pkg::IDX_W;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            reserved_reg  <= reserved_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        blk_reg        <= blk_next;
        cls_reg        <= cls_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        rsp_status_reg <= rsp_status_next;
        rsp_addr_reg   <= rsp_addr_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        pages_next      = pages_reg;
        reserved_next   = reserved_reg;
        size_next       = size_reg;
        blk_next        = blk_reg;
        cls_next        = cls_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        link_req        = '{we: 1'b0, addr: blk_reg, wdata: head_reg[cls_reg]};
        cls_req         = '{we: 1'b0, addr: blk_reg, wdata: cls_reg};

        if (cfg.valid)
        begin
            reserved_next = cfg.reserved_pages;
        end

        case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    size_next       = req.size;
                    blk_next        = free_off[psa_pkg::ADDR_W-1:psa_pkg::MIN_SHIFT];
                    res_status_next = psa_pkg::STATUS_OK;
                    res_addr_next   = '0;
                    state_next      = (req.op == psa_pkg::OP_FREE)
                                      ? psa_pkg::ST_FREE_RD : psa_pkg::ST_CLASSIFY;
                end
            end
            psa_pkg::ST_CLASSIFY:
            begin
                cls_next = sel.cls;
                off_next = '0;
                if (sel.too_large)
                begin
                    res_status_next = psa_pkg::STATUS_TOO_LARGE;
                    state_next      = psa_pkg::ST_RESP;
                end
                else if (head_reg[sel.cls][psa_pkg::IDX_W])
                begin
                    if (pages_reg >= limit || int'(sel.cls) > psa_pkg::OFF_W)
                    begin
                        res_status_next = psa_pkg::STATUS_EXHAUSTED;
                        state_next      = psa_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = psa_pkg::ST_CARVE;
                    end
                end
                else
                begin
                    state_next = psa_pkg::ST_POP_RD;
                end
            end
            psa_pkg::ST_CARVE:
            begin
                // Push one block a cycle, lowest first.
                link_req           = '{we: 1'b1, addr: carve_idx, wdata: head_reg[cls_reg]};
                head_next[cls_reg] = {1'b0, carve_idx};
                off_next           = off_sum[psa_pkg::OFF_W-1:0];
                if (off_sum[psa_pkg::OFF_W])
                begin
                    pages_next = pages_reg + psa_pkg::PAGE_CNT_W'(1);
                    state_next = psa_pkg::ST_POP_RD;
                end
            end
            psa_pkg::ST_POP_RD:
            begin
                link_req.addr = head_idx;
                blk_next      = head_idx;
                state_next    = psa_pkg::ST_POP_WAIT;
            end
            psa_pkg::ST_POP_WAIT:
            begin
                head_next[cls_reg] = link_rdata;
                cls_req            = '{we: 1'b1, addr: blk_reg, wdata: cls_reg};
                res_addr_next      = psa_pkg::ADDR_W'({blk_reg, psa_pkg::MIN_SHIFT'(0)})
                                     + psa_pkg::ADDR_W'(psa_pkg::HEADER_BYTES);
                state_next         = psa_pkg::ST_RESP;
            end
            psa_pkg::ST_FREE_RD:
            begin
                state_next = psa_pkg::ST_FREE_WAIT;
            end
            psa_pkg::ST_FREE_WAIT:
            begin
                link_req             = '{we: 1'b1, addr: blk_reg, wdata: head_reg[cls_rdata]};
                head_next[cls_rdata] = {1'b0, blk_reg};
                state_next           = psa_pkg::ST_RESP;
            end
            psa_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_addr_next   = res_addr_reg;
                    state_next      = psa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psa_pkg::ST_IDLE;
            end
        endcase
    end

    `PSA_ASSERT_NOW(a_pages_bound, clk, rst_n, 1'b1,
        pages_reg <= psa_pkg::PAGE_CNT_W'(psa_pkg::REGION_PAGES))
    `PSA_ASSERT_NEXT(a_alloc_classify, clk, rst_n, acc && req.op == psa_pkg::OP_ALLOC,
        state_reg == psa_pkg::ST_CLASSIFY)
    `PSA_ASSERT_NOW(a_carve_writes, clk, rst_n, state_reg == psa_pkg::ST_CARVE,
        link_req.we && !cls_req.we)
    `PSA_ASSERT_NEXT(a_carve_page_step, clk, rst_n,
        state_reg == psa_pkg::ST_CARVE && state_next == psa_pkg::ST_POP_RD,
        pages_reg == psa_pkg::PAGE_CNT_W'($past(pages_reg) + psa_pkg::PAGE_CNT_W'(1)))
endmodule
`default_nettype wire

// ===== src/pot_size_class_slab_allocator.sv =====
// Top level of the power-of-two size-class allocator.
// Steps from request accept: free FREE_RD, FREE_WAIT, RESP; allocate from a non-empty list
//   CLASSIFY, POP_RD, POP_WAIT, RESP; too large or exhausted CLASSIFY, RESP; a list that must
//   be refilled adds CARVE before POP_RD, one block per step (page bytes / block bytes, 2 to 256).
// Throughput: one request at a time, taken the cycle after the response is loaded; set by
//   the single-port link RAM and the carve loop.
// Reset: asynchronous, active low; all lists empty, no pages carved, reserved_pages 256.
// Link and class RAMs need no clearing: an entry is always written before it is read.
`default_nettype none
module pot_size_class_slab_allocator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psa_req_if.sink     req,
    psa_rsp_if.source   rsp,
    psa_cfg_if.sink     cfg
);
    psa_pkg::link_req_t              link_req;
    psa_pkg::cls_req_t               cls_req;
    logic [psa_pkg::HEAD_W-1:0]      link_rdata;
    logic [psa_pkg::CLASS_W-1:0]     cls_rdata;

    // Sequencer: classify, carve, pop and push; owns the list heads and result register.
    psa_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .cls_req    (cls_req),
        .cls_rdata  (cls_rdata)
    );

    // Next-block links, one per minimum-sized block slot.
    psa_ram #(
        .WIDTH (psa_pkg::HEAD_W),
        .DEPTH (psa_pkg::SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .addr  (link_req.addr),
        .wdata (link_req.wdata),
        .rdata (link_rdata)
    );

    // Class recorded at allocation, read back on free.
    psa_ram #(
        .WIDTH (psa_pkg::CLASS_W),
        .DEPTH (psa_pkg::SLOTS)
    ) u_class_ram (
        .clk   (clk),
        .we    (cls_req.we),
        .addr  (cls_req.addr),
        .wdata (cls_req.wdata),
        .rdata (cls_rdata)
    );
endmodule
`default_nettype wire
